// ===== rtl/ssde_pkg.sv =====
// Package for the sound sample DMA engine: item and result types,
// port decode constants, function codes and the rate reload table.
// No dependencies.
`default_nettype none

package ssde_pkg;

  // function codes of one input item
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // I/O port numbers
  localparam logic [7:0] PORT_SRC_LO  = 8'h4A;
  localparam logic [7:0] PORT_SRC_MID = 8'h4B;
  localparam logic [7:0] PORT_SRC_HI  = 8'h4C;
  localparam logic [7:0] PORT_LEN_LO  = 8'h4E;
  localparam logic [7:0] PORT_LEN_MID = 8'h4F;
  localparam logic [7:0] PORT_LEN_HI  = 8'h50;
  localparam logic [7:0] PORT_CTRL    = 8'h52;

  // control register bit positions
  localparam int unsigned CTL_ENABLE_BIT = 7;
  localparam int unsigned CTL_DOWN_BIT   = 6;
  localparam int unsigned CTL_ZERO_BIT   = 5;
  localparam int unsigned CTL_PORT_BIT   = 4;
  localparam int unsigned CTL_LOOP_BIT   = 3;

  localparam int unsigned LEN_BITS   = 20;
  localparam int unsigned FETCH_BITS = 20;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] port_number;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0]            read_data;
    logic                  fetch_valid;
    logic [FETCH_BITS-1:0] fetch_address;
    logic                  target_port;
  } result_t;

  // wait counter value loaded after a fetch
  function automatic logic [2:0] rate_reload(logic [1:0] rate);
    logic [2:0] r;
    case (rate)
      2'd0:    r = 3'd5;
      2'd1:    r = 3'd3;
      2'd2:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // replace byte idx of a 32-bit word
  function automatic logic [31:0] set_byte(logic [31:0] w, logic [1:0] idx, logic [7:0] v);
    logic [31:0] r;
    r = w;
    case (idx)
      2'd0:    r[7:0]   = v;
      2'd1:    r[15:8]  = v;
      2'd2:    r[23:16] = v;
      default: r[31:24] = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sound_sample_dma_engine_unit.sv =====
// Sound sample DMA engine, top level: input register, state update and
// result register; a transfer passes the input then the result register.
// Throughput: one item per cycle while out_ready_i does not stall; the single
// state update stage sets it, and the result register lets a new item
// enter while a result waits. Reset (async, active low) clears all engine
// registers and both stages. Depends on ssde_pkg and ssde_core.
`default_nettype none

module sound_sample_dma_engine_unit import ssde_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [7:0]            port_number_i,
  input  wire logic [7:0]            write_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            read_data_o,
  output      logic                  fetch_valid_o,
  output      logic [FETCH_BITS-1:0] fetch_address_o,
  output      logic                  target_port_o
);

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q, core_res;
  logic    out_free, advance, in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  ssde_core #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.func        <= func_i;
      s1_item_q.port_number <= port_number_i;
      s1_item_q.write_data  <= write_data_i;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_res_q.read_data;
  assign fetch_valid_o   = out_res_q.fetch_valid;
  assign fetch_address_o = out_res_q.fetch_address;
  assign target_port_o   = out_res_q.target_port;

  a_fetch_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fetch_valid_o |-> read_data_o == '0)
    else $error("fetch result carries read data");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item lost before result register");

  a_in_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted transfer lost in input register");

endmodule

`default_nettype wire

// ===== rtl/ssde_core.sv =====
// Register file and tick logic of the sound sample DMA engine.
// Holds source/length registers, shadows, control and wait counter.
// Depends on ssde_pkg.
`default_nettype none

module ssde_core import ssde_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 20
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire item_t   item_i,
  output      result_t res_o
);

  logic [ADDRESS_BITS-1:0] src_q, src_d, src_shadow_q, src_shadow_d;
  logic [LEN_BITS-1:0]     len_q, len_d, len_shadow_q, len_shadow_d;
  logic [7:0]              ctl_q, ctl_d;
  logic [2:0]              wait_q, wait_d;

  logic [31:0]             src_ext, src_wr;
  logic [31:0]             len_wr;
  logic [7:0]              src_off, len_off;
  logic [ADDRESS_BITS-1:0] src_step;
  logic [LEN_BITS-1:0]     len_dec;
  logic                    tick_en;

  assign src_ext  = 32'(src_q);
  assign src_off  = item_i.port_number - PORT_SRC_LO;
  assign len_off  = item_i.port_number - PORT_LEN_LO;
  assign src_wr   = set_byte(src_ext, src_off[1:0], item_i.write_data);
  assign len_wr   = set_byte(32'(len_q), len_off[1:0], item_i.write_data);
  assign src_step = ctl_q[CTL_DOWN_BIT] ? src_q - ADDRESS_BITS'(1) : src_q + ADDRESS_BITS'(1);
  assign len_dec  = len_q - LEN_BITS'(1);
  assign tick_en  = (item_i.func == FUNC_TICK) && ctl_q[CTL_ENABLE_BIT];

  always_comb begin
    src_d        = src_q;
    src_shadow_d = src_shadow_q;
    len_d        = len_q;
    len_shadow_d = len_shadow_q;
    ctl_d        = ctl_q;
    wait_d       = wait_q;
    res_o        = '0;

    if (item_i.func == FUNC_WRITE) begin
      unique case (item_i.port_number) inside
        PORT_SRC_LO, PORT_SRC_MID, PORT_SRC_HI: begin
          src_d        = src_wr[ADDRESS_BITS-1:0];
          src_shadow_d = src_wr[ADDRESS_BITS-1:0];
        end
        PORT_LEN_LO, PORT_LEN_MID, PORT_LEN_HI: begin
          len_d        = len_wr[LEN_BITS-1:0];
          len_shadow_d = len_wr[LEN_BITS-1:0];
        end
        PORT_CTRL: begin
          ctl_d               = item_i.write_data;
          ctl_d[CTL_ZERO_BIT] = 1'b0;
        end
        default: ;
      endcase
    end else if (item_i.func == FUNC_READ) begin
      unique case (item_i.port_number)
        PORT_SRC_LO:  res_o.read_data = src_ext[7:0];
        PORT_SRC_MID: res_o.read_data = src_ext[15:8];
        PORT_SRC_HI:  res_o.read_data = src_ext[23:16];
        PORT_LEN_LO:  res_o.read_data = len_q[7:0];
        PORT_LEN_MID: res_o.read_data = len_q[15:8];
        PORT_LEN_HI:  res_o.read_data = {4'b0000, len_q[19:16]};
        PORT_CTRL:    res_o.read_data = ctl_q;
        default:      res_o.read_data = '0;
      endcase
    end else if (tick_en) begin
      if (wait_q == 3'd0) begin
        res_o.fetch_valid   = 1'b1;
        res_o.fetch_address = src_ext[FETCH_BITS-1:0];
        res_o.target_port   = ctl_q[CTL_PORT_BIT];
        src_d = src_step;
        len_d = len_dec;
        if (len_dec == '0) begin
          if (ctl_q[CTL_LOOP_BIT]) begin
            len_d = len_shadow_q;
            src_d = src_shadow_q;
          end else begin
            ctl_d[CTL_ENABLE_BIT] = 1'b0;
          end
        end
        wait_d = rate_reload(ctl_q[1:0]);
      end else begin
        wait_d = wait_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q        <= '0;
      src_shadow_q <= '0;
      len_q        <= '0;
      len_shadow_q <= '0;
      ctl_q        <= '0;
      wait_q       <= '0;
    end else if (step_i) begin
      src_q        <= src_d;
      src_shadow_q <= src_shadow_d;
      len_q        <= len_d;
      len_shadow_q <= len_shadow_d;
      ctl_q        <= ctl_d;
      wait_q       <= wait_d;
    end
  end

  a_ctl_zero_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_q[CTL_ZERO_BIT])
    else $error("control bit 5 set");

  a_wait_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.fetch_valid |=> wait_q == rate_reload($past(ctl_q[1:0])))
    else $error("wait counter not reloaded after fetch");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.func == FUNC_TICK && !ctl_q[CTL_ENABLE_BIT]
      |=> $stable(src_q) && $stable(len_q) && $stable(wait_q))
    else $error("disabled tick changed state");

endmodule

`default_nettype wire
